/* sv/tss_pkg.sv */
// Shared constants, signature table and byte folding for the threat signature scanner.
// Depends on nothing; the top level, cell, comparator and checker refer to it by scoped names.
package tss_pkg;

	localparam int WIN_DEPTH = 22;            // stored bytes before the current one
	localparam int WIN_TAPS  = WIN_DEPTH + 1; // current byte plus the stored window
	localparam int SIG_COUNT = 22;
	localparam int SIG_BITS  = 8 * WIN_TAPS;  // longest signature fills every tap

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] LOWER_X   = 8'h78;
	localparam logic [7:0] UPPER_A   = 8'h41;
	localparam logic [7:0] UPPER_Z   = 8'h5A;
	localparam logic [7:0] CASE_GAP  = 8'h20;
	localparam logic [7:0] ESC_MAX   = 8'hFF;

	localparam logic [2:0] LVL_NONE = 3'd0;
	localparam logic [2:0] LVL_LOW  = 3'd1;
	localparam logic [2:0] LVL_MED  = 3'd2;
	localparam logic [2:0] LVL_HIGH = 3'd3;
	localparam logic [2:0] LVL_CRIT = 3'd4;

	// Text is right-justified: the byte that ends the signature sits in bits [7:0].
	localparam logic [SIG_BITS-1:0] SIG_TEXT [SIG_COUNT] = '{
		SIG_BITS'("jailbreak"),
		SIG_BITS'("meterpreter"),
		SIG_BITS'("mimikatz"),
		SIG_BITS'({"reverse", "_tcp"}),
		SIG_BITS'({"bind", "_shell"}),
		SIG_BITS'("cobalt strike"),
		SIG_BITS'("${jndi:"),
		SIG_BITS'("ignore all previous"),
		SIG_BITS'("ignore your instruction"),
		SIG_BITS'("disregard all prior"),
		SIG_BITS'("system prompt:"),
		SIG_BITS'("'; drop table"),
		SIG_BITS'("union select"),
		SIG_BITS'("<script>"),
		SIG_BITS'("../../../"),
		SIG_BITS'("you are now"),
		SIG_BITS'("pretend you are"),
		SIG_BITS'("base64"),
		SIG_BITS'("bypass"),
		SIG_BITS'("password"),
		SIG_BITS'("secret"),
		SIG_BITS'("api key")
	};

	localparam int SIG_LEN [SIG_COUNT] = '{
		9, 11, 8, 11, 10, 13, 7, 19, 23, 19, 14,
		13, 12, 8, 9, 11, 15, 6, 6, 8, 6, 7
	};

	localparam logic [2:0] SIG_LEVEL [SIG_COUNT] = '{
		LVL_CRIT, LVL_CRIT, LVL_CRIT, LVL_CRIT, LVL_CRIT, LVL_CRIT, LVL_CRIT,
		LVL_HIGH, LVL_HIGH, LVL_HIGH, LVL_HIGH, LVL_HIGH, LVL_HIGH, LVL_HIGH,
		LVL_HIGH, LVL_MED, LVL_MED, LVL_MED, LVL_MED, LVL_LOW, LVL_LOW, LVL_LOW
	};

	// Fold A-Z to lower case; every other byte passes unchanged.
	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= UPPER_A && c <= UPPER_Z) begin
			return c + CASE_GAP;
		end
		return c;
	endfunction

endpackage

/* sv/tss_ifs.sv */
// Channel interfaces of the threat signature scanner: message bytes, verdicts, limit writes.
// Depends on nothing; the top level and the checker bind to their members.
interface tss_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tss_level_if;
	logic       valid;
	logic       ready;
	logic [2:0] threat_level;

	modport source (output valid, output threat_level, input ready);
	modport sink   (input valid, input threat_level, output ready);
endinterface

interface tss_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] hex_escape_limit;

	modport source (output valid, output hex_escape_limit, input ready);
	modport sink   (input valid, input hex_escape_limit, output ready);
endinterface

/* sv/threat_signature_scanner.sv */
// Top level of the threat signature scanner: cell chain, signature comparator, verdict register.
// Depends on tss_pkg, tss_ifs, tss_cell and tss_match.
//
//  channel | role | payload                   | beat moves
//  --------+------+---------------------------+-----------------------------------
//  msg     | sink | data_byte[7:0], last_byte | one message byte
//  verdict | src  | threat_level[2:0]         | one verdict, after each last byte
//  cfg     | sink | hex_escape_limit[7:0]     | new escape limit, always ready
//
// One byte is taken each cycle that msg.ready is high. All signature compares for a byte are
// done in the cycle it arrives, against the 22-cell chain plus the byte itself; the chain
// advances one cell per beat; the last byte clears it. The verdict appears in the cycle after
// the last byte. msg.ready drops only while a verdict is held and verdict.ready is low.
// Reset clears the chain, running level, escape count and verdict; the limit returns to 5.
module threat_signature_scanner (
	input  logic               clk,
	input  logic               arst_n,
	tss_byte_if.sink           msg,
	tss_level_if.source        verdict,
	tss_cfg_if.sink            cfg
);

	localparam logic [7:0] LIMIT_RESET = 8'd5;

	// Window chain: raw bytes for the escape check, folded bytes for matching.
	logic [tss_pkg::WIN_DEPTH-1:0][7:0] cell_raw;
	logic [tss_pkg::WIN_TAPS-1:0][7:0]  win_fold;
	logic                               accept;
	logic                               shift_en;
	logic                               clear;

	logic [2:0] hit_level;
	logic [2:0] level_q;
	logic [2:0] level_now;
	logic [2:0] level_final;
	logic [7:0] escape_q;
	logic [7:0] escape_next;
	logic       escape_hit;
	logic [7:0] limit_q;

	logic       out_valid_q;
	logic [2:0] out_level_q;

	// Take a byte unless a verdict is stuck in the output register.
	assign msg.ready = !out_valid_q || verdict.ready;
	assign accept    = msg.valid && msg.ready;
	// Advance on ordinary bytes; drop the whole window when the message ends.
	assign shift_en  = accept && !msg.last_byte;
	assign clear     = accept && msg.last_byte;

	assign win_fold[0] = tss_pkg::fold(msg.data_byte);

	for (genvar j = 0; j < tss_pkg::WIN_DEPTH; j++) begin : g_cell
		if (j == 0) begin : g_head
			tss_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.clear    (clear),
				.d        (msg.data_byte),
				.q        (cell_raw[j]),
				.folded   (win_fold[j+1])
			);
		end else begin : g_body
			tss_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.clear    (clear),
				.d        (cell_raw[j-1]),
				.q        (cell_raw[j]),
				.folded   (win_fold[j+1])
			);
		end
	end

	tss_match u_match (
		.win       (win_fold),
		.hit_level (hit_level)
	);

	// Cleared cells hold zero, which no signature contains, so a match can never
	// reach back into a previous message. The same holds for the escape pair:
	// cell 2 is zero until three bytes of this message are stored.
	assign level_now  = (hit_level > level_q) ? hit_level : level_q;
	assign escape_hit = (cell_raw[2] == tss_pkg::BACKSLASH) &&
		(cell_raw[1] == tss_pkg::LOWER_X) && (escape_q != tss_pkg::ESC_MAX);
	assign escape_next = escape_q + {7'd0, escape_hit};
	assign level_final = ((escape_next > limit_q) && (level_now < tss_pkg::LVL_HIGH)) ?
		tss_pkg::LVL_HIGH : level_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= tss_pkg::LVL_NONE;
			escape_q <= '0;
		end else if (clear) begin
			level_q  <= tss_pkg::LVL_NONE;
			escape_q <= '0;
		end else if (shift_en) begin
			level_q  <= level_now;
			escape_q <= escape_next;
		end
	end

	// Escape limit register; writes must arrive only while the block is idle (not enforced here).
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.hex_escape_limit;
		end
	end

	// Verdict register: load on the last byte, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			out_level_q <= level_final;
		end
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.threat_level = out_level_q;

endmodule

/* sv/tss_cell.sv */
// One window cell: holds one raw message byte, passed to the next cell on each shift_en.
// Depends on tss_pkg for case folding.
module tss_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       clear,
	input  logic [7:0] d,
	output logic [7:0] q,
	output logic [7:0] folded
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q      = byte_q;
	assign folded = tss_pkg::fold(byte_q);

endmodule

/* sv/tss_match.sv */
// Signature comparator: checks every signature ending at the current byte, gives the top level.
// Depends on tss_pkg for the signature table and level codes.
module tss_match (
	input  logic [tss_pkg::WIN_TAPS-1:0][7:0] win,   // folded; tap 0 is the current byte
	output logic [2:0]                        hit_level
);

	logic [tss_pkg::SIG_COUNT-1:0]                       sig_hit;
	logic [tss_pkg::SIG_COUNT-1:0][tss_pkg::WIN_TAPS-1:0] tap_ok;
	logic [4:0]                                          lvl_hit;

	for (genvar i = 0; i < tss_pkg::SIG_COUNT; i++) begin : g_sig
		for (genvar k = 0; k < tss_pkg::WIN_TAPS; k++) begin : g_tap
			// Taps beyond the signature length always pass.
			assign tap_ok[i][k] = (k >= tss_pkg::SIG_LEN[i]) ||
				(win[k] == tss_pkg::SIG_TEXT[i][8*k +: 8]);
		end
		assign sig_hit[i] = &tap_ok[i];
	end

	always_comb begin
		lvl_hit = '0;
		for (int i = 0; i < tss_pkg::SIG_COUNT; i++) begin
			if (sig_hit[i]) begin
				lvl_hit[tss_pkg::SIG_LEVEL[i]] = 1'b1;
			end
		end
	end

	always_comb begin
		priority if (lvl_hit[tss_pkg::LVL_CRIT]) begin
			hit_level = tss_pkg::LVL_CRIT;
		end else if (lvl_hit[tss_pkg::LVL_HIGH]) begin
			hit_level = tss_pkg::LVL_HIGH;
		end else if (lvl_hit[tss_pkg::LVL_MED]) begin
			hit_level = tss_pkg::LVL_MED;
		end else if (lvl_hit[tss_pkg::LVL_LOW]) begin
			hit_level = tss_pkg::LVL_LOW;
		end else begin
			hit_level = tss_pkg::LVL_NONE;
		end
	end

endmodule

/* sv/tss_checker.sv */
// Port-level checks for the threat signature scanner and the bind that attaches them.
// Depends on tss_pkg level codes and the top level's interface ports.
module tss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_ready,
	input logic       msg_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_level
);

	// A verdict appears only after a last byte was taken.
	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(msg_valid && msg_ready && msg_last))
		else $error("verdict without a last byte");

	// Backpressure on bytes comes only from a stalled verdict.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!msg_ready |-> (out_valid && !out_ready))
		else $error("byte input stalled without a stalled verdict");

	// Levels never exceed critical.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_level <= tss_pkg::LVL_CRIT))
		else $error("threat level out of range");

	// A stalled verdict holds.
	a_verdict_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_level)))
		else $error("stalled verdict changed");

endmodule

bind threat_signature_scanner tss_checker u_tss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg.valid),
	.msg_ready (msg.ready),
	.msg_last  (msg.last_byte),
	.out_valid (verdict.valid),
	.out_ready (verdict.ready),
	.out_level (verdict.threat_level)
);
